[rtl/bit_vector_boolean_op_macros.svh]
// Assertion helpers used by the checker file.
`ifndef BIT_VECTOR_BOOLEAN_OP_MACROS_SVH
`define BIT_VECTOR_BOOLEAN_OP_MACROS_SVH

// Clocked property, ignored while reset is high
`define BVBO_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked during reset
`define BVBO_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/bvbo_pkg.sv]
`timescale 1ns / 1ps
package bvbo_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 20;
   localparam int INDEX_WIDTH         = 18;
   localparam int OFFSET_WIDTH        = 3;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam logic [7:0] BYTE_ONES   = 8'hFF;

   // result queue depth, kept a power of two
   localparam int FIFO_DEPTH = 4;

   typedef enum logic [3:0] {
      OP_CLR, OP_SET, OP_FIRST, OP_SECOND, OP_C1, OP_C2, OP_AND, OP_IOR,
      OP_XOR, OP_EQV, OP_NAND, OP_NOR, OP_ANDC1, OP_ANDC2, OP_ORC1, OP_ORC2
   } op_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_OP_CODE, CSR_FIRST_OFFSET, CSR_SECOND_OFFSET, CSR_DEST_OFFSET,
      CSR_BIT_COUNT
   } csr_index_type;

   typedef struct packed {
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [7:0] old_dest_byte;
      logic       last_item;
   } req_item_type;

   typedef struct packed {
      logic [7:0]             result_byte;
      logic [INDEX_WIDTH-1:0] dest_index;
      logic                   last_result;
   } rsp_item_type;

   // static settings seen by the datapath
   typedef struct packed {
      op_type                  op_code;
      logic [OFFSET_WIDTH-1:0] first_offset;
      logic [OFFSET_WIDTH-1:0] second_offset;
      logic [OFFSET_WIDTH-1:0] dest_offset;
   } cfg_type;

   // zero, one or two results produced in one cycle, in order
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

   function automatic logic [7:0] combine(input op_type op, input logic [7:0] a,
                                          input logic [7:0] b);
      logic [7:0] v;
      case (op)
         OP_CLR:    v = 8'h00;
         OP_SET:    v = BYTE_ONES;
         OP_FIRST:  v = a;
         OP_SECOND: v = b;
         OP_C1:     v = ~a;
         OP_C2:     v = ~b;
         OP_AND:    v = a & b;
         OP_IOR:    v = a | b;
         OP_XOR:    v = a ^ b;
         OP_EQV:    v = ~(a ^ b);
         OP_NAND:   v = ~(a & b);
         OP_NOR:    v = ~(a | b);
         OP_ANDC1:  v = ~a & b;
         OP_ANDC2:  v = a & ~b;
         OP_ORC1:   v = ~a | b;
         OP_ORC2:   v = a | ~b;
         default:   v = 8'h00;
      endcase
      return v;
   endfunction

   // byte starting at bit o of the pair hi:lo, MSB first
   function automatic logic [7:0] align(input logic [7:0] hi, input logic [7:0] lo,
                                        input logic [OFFSET_WIDTH-1:0] o);
      logic [15:0] pair;
      pair = {hi, lo} << o;
      return pair[15:8];
   endfunction

   // move a realigned byte back out to the destination offset
   function automatic logic [7:0] place_bits(input logic [7:0] cur,
                                             input logic [7:0] prior,
                                             input logic [OFFSET_WIDTH-1:0] ro);
      logic [15:0] pair;
      pair = {prior, cur} >> ro;
      return pair[7:0];
   endfunction

endpackage

[rtl/bvbo_fifo.sv]
`timescale 1ns / 1ps
module bvbo_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  bvbo_pkg::push_type     push,
   output logic                   room,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output bvbo_pkg::rsp_item_type rsp_item
);
   import bvbo_pkg::*;

   localparam int PTR_WIDTH   = $clog2(FIFO_DEPTH);
   localparam int COUNT_WIDTH = $clog2(FIFO_DEPTH + 1);

   rsp_item_type           entry_ff [FIFO_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   pop;

   // room for a full pair of results
   assign room      = (count_ff <= COUNT_WIDTH'(FIFO_DEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_WIDTH'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_WIDTH'(pop);
      count_in  = count_ff + COUNT_WIDTH'(push.count) - COUNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, up to two writes per cycle
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + PTR_WIDTH'(1)] <= push.second;
      end
   end

endmodule

[rtl/bvbo_core.sv]
`timescale 1ns / 1ps
module bvbo_core #(
   parameter int COUNT_WIDTH = bvbo_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  bvbo_pkg::req_item_type item,
   input  bvbo_pkg::cfg_type      cfg,
   input  logic [COUNT_WIDTH:0]   end_pos,
   output bvbo_pkg::push_type     push
);
   import bvbo_pkg::*;

   localparam int EW = COUNT_WIDTH + 1;
   localparam int HW = EW - 3;
   localparam int CW = (HW > INDEX_WIDTH) ? HW : INDEX_WIDTH;

   logic [7:0]             prev_first_ff, prev_second_ff, prev_dest_ff, prev_logical_ff;
   logic [INDEX_WIDTH-1:0] byte_counter_ff;

   logic [INDEX_WIDTH-1:0] k_prev;
   logic                   fresh;
   logic [7:0]             lprev, lcur, mask0, mask1;
   rsp_item_type           res0, res1;

   // run mask of destination byte m: end_pos is dest_offset + bit_count
   function automatic logic [7:0] run_mask(input logic [INDEX_WIDTH-1:0] m,
                                           input logic [EW-1:0] endp,
                                           input logic [OFFSET_WIDTH-1:0] doff);
      logic [CW-1:0] end_hi;
      logic [CW-1:0] m_ext;
      logic [3:0]    s;
      logic [3:0]    e;
      end_hi = CW'(endp[EW-1:3]);
      m_ext  = CW'(m);
      s = (m == '0) ? {1'b0, doff} : 4'd0;
      if (end_hi > m_ext) begin
         e = 4'd8;
      end else if (end_hi == m_ext) begin
         e = {1'b0, endp[2:0]};
      end else begin
         e = 4'd0;
      end
      return (BYTE_ONES >> s) & ~(BYTE_ONES >> e);
   endfunction

   // combine, realign and merge for the finished byte and the flushed byte
   always_comb begin
      fresh  = (byte_counter_ff == '0);
      k_prev = byte_counter_ff - INDEX_WIDTH'(1);
      lprev  = fresh ? 8'h00
             : combine(cfg.op_code,
                       align(prev_first_ff, item.first_byte, cfg.first_offset),
                       align(prev_second_ff, item.second_byte, cfg.second_offset));
      lcur   = combine(cfg.op_code,
                       align(item.first_byte, 8'h00, cfg.first_offset),
                       align(item.second_byte, 8'h00, cfg.second_offset));
      mask0  = run_mask(k_prev, end_pos, cfg.dest_offset);
      mask1  = run_mask(byte_counter_ff, end_pos, cfg.dest_offset);

      res0.result_byte = (place_bits(lprev, prev_logical_ff, cfg.dest_offset) & mask0)
                       | (prev_dest_ff & ~mask0);
      res0.dest_index  = k_prev;
      res0.last_result = 1'b0;

      res1.result_byte = (place_bits(lcur, lprev, cfg.dest_offset) & mask1)
                       | (item.old_dest_byte & ~mask1);
      res1.dest_index  = byte_counter_ff;
      res1.last_result = 1'b1;

      push.count  = advance ? ({1'b0, !fresh} + {1'b0, item.last_item}) : 2'd0;
      push.first  = fresh ? res1 : res0;
      push.second = res1;
   end

   // stream state, back to zero after a last item
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_first_ff   <= '0;
         prev_second_ff  <= '0;
         prev_dest_ff    <= '0;
         prev_logical_ff <= '0;
         byte_counter_ff <= '0;
      end else if (advance) begin
         if (item.last_item) begin
            prev_first_ff   <= '0;
            prev_second_ff  <= '0;
            prev_dest_ff    <= '0;
            prev_logical_ff <= '0;
            byte_counter_ff <= '0;
         end else begin
            prev_first_ff   <= item.first_byte;
            prev_second_ff  <= item.second_byte;
            prev_dest_ff    <= item.old_dest_byte;
            prev_logical_ff <= lprev;
            byte_counter_ff <= byte_counter_ff + INDEX_WIDTH'(1);
         end
      end
   end

endmodule

[rtl/bit_vector_boolean_op.sv]
// A result passes through the input register and the result queue before it can be taken.
// Throughput: one item per cycle; each item gives one result, except the first
// of a stream (none) and a last item (two); the input stalls only when the
// four-entry result queue cannot take a pair, which needs a stalling receiver.
// Reset clears the stream state and the result queue, and sets op_code to and,
// all offsets and bit_count to zero.
`timescale 1ns / 1ps
module bit_vector_boolean_op #(
   parameter int COUNT_WIDTH = bvbo_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  bvbo_pkg::req_item_type                  req_item,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output bvbo_pkg::rsp_item_type                  rsp_item,
   input  logic                                    csr_we,
   input  logic [bvbo_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [COUNT_WIDTH-1:0]                  csr_wdata
);
   import bvbo_pkg::*;

   cfg_type              cfg_ff;
   logic [COUNT_WIDTH-1:0] bit_count_ff;
   logic [COUNT_WIDTH:0]   end_pos_ff;

   req_item_type         item_ff;
   logic                 item_valid_ff;
   logic                 room, advance, accept;
   push_type             push;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.op_code       <= OP_AND;
         cfg_ff.first_offset  <= '0;
         cfg_ff.second_offset <= '0;
         cfg_ff.dest_offset   <= '0;
         bit_count_ff         <= '0;
         end_pos_ff           <= '0;
      end else begin
         end_pos_ff <= (COUNT_WIDTH + 1)'(cfg_ff.dest_offset)
                     + (COUNT_WIDTH + 1)'(bit_count_ff);
         if (csr_we) begin
            case (csr_index)
               CSR_OP_CODE:       cfg_ff.op_code       <= op_type'(csr_wdata[3:0]);
               CSR_FIRST_OFFSET:  cfg_ff.first_offset  <= csr_wdata[OFFSET_WIDTH-1:0];
               CSR_SECOND_OFFSET: cfg_ff.second_offset <= csr_wdata[OFFSET_WIDTH-1:0];
               CSR_DEST_OFFSET:   cfg_ff.dest_offset   <= csr_wdata[OFFSET_WIDTH-1:0];
               CSR_BIT_COUNT:     bit_count_ff         <= csr_wdata;
               default:           ;
            endcase
         end
      end
   end

   // input register: moves on whenever the queue can take a pair
   assign advance   = item_valid_ff && room;
   assign req_stall = item_valid_ff && !room;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (accept) begin
         item_valid_ff <= 1'b1;
      end else if (advance) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   bvbo_core #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg_ff),
      .end_pos (end_pos_ff),
      .push    (push)
   );

   bvbo_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

[rtl/bvbo_checker.sv]
`timescale 1ns / 1ps
`include "bit_vector_boolean_op_macros.svh"
module bvbo_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input bvbo_pkg::rsp_item_type rsp_item
);
   import bvbo_pkg::*;

   logic                   after_last_ff;
   logic [INDEX_WIDTH-1:0] prev_index_ff;
   logic [INDEX_WIDTH-1:0] next_index;
   logic                   rsp_accept;

   assign rsp_accept = rsp_valid && !rsp_stall;
   assign next_index = prev_index_ff + INDEX_WIDTH'(1);

   // track where the result stream stands
   always_ff @(posedge clock) begin
      if (reset) begin
         after_last_ff <= 1'b1;
         prev_index_ff <= '0;
      end else if (rsp_accept) begin
         after_last_ff <= rsp_item.last_result;
         prev_index_ff <= rsp_item.dest_index;
      end
   end

   `BVBO_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item), "stalled result item changed")
   `BVBO_ASSERT_NR(a_reset_empty, clock, reset |=> !rsp_valid, "result valid right after reset")
   `BVBO_ASSERT(a_stream_start, clock, reset, rsp_accept && after_last_ff |-> rsp_item.dest_index == '0, "stream does not start at byte zero")
   `BVBO_ASSERT(a_index_step, clock, reset, rsp_accept && !after_last_ff |-> (rsp_item.dest_index == next_index) || (rsp_item.dest_index == '0), "destination index skipped")

endmodule

bind bit_vector_boolean_op bvbo_checker u_bvbo_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);
